FILE: hdl/svpm_pkg.sv
// ----------------------------------------------------------------------------
// svpm_pkg
// Types and constants shared by the sleep vote power manager modules.
// ----------------------------------------------------------------------------
package svpm_pkg;

  localparam logic [1:0] KIND_HOLD  = 2'd0;
  localparam logic [1:0] KIND_UNTIL = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;
  localparam logic [1:0] KIND_CHECK = 2'd3;

  localparam logic [1:0] ST_HOLD  = 2'd0;
  localparam logic [1:0] ST_FREE  = 2'd1;
  localparam logic [1:0] ST_UNTIL = 2'd2;

  localparam logic [1:0] ACT_AWAKE = 2'd0;
  localparam logic [1:0] ACT_WAKE  = 2'd1;
  localparam logic [1:0] ACT_SLEEP = 2'd2;
  localparam logic [1:0] ACT_FULL  = 2'd3;

  localparam logic [15:0] MIN_SLEEP_RESET = 16'd2000;
  localparam int          MAX_RESULTS     = 3;

  localparam logic [1:0] REG_CURRENT_MODE = 2'd0;
  localparam logic [1:0] REG_MIN_SLEEP    = 2'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] client_tag;
    logic [30:0] duration_ms;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] sleep_ms;
    logic [1:0]         next_mode;
    logic               last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic lookup;    // tag search step
    logic alloc;     // apply allocation / vote write
    logic scan_ent;  // process one table entry
    logic scan_mode; // check one mode stamp for wake
    logic stamp;     // write own stamp
    logic near_step; // nearest-mode search step
    logic emit_wake; // push wake result
    logic emit_fin;  // push final result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ent_done;
    logic mode_done;
    logic near_done;
    logic full;
    logic is_hold;
    logic is_check;
    logic awake;
    logic wake_hit;
    logic out_busy;
  } sts_t;

endpackage

FILE: hdl/sleep_vote_power_manager_top.sv
// ----------------------------------------------------------------------------
// sleep_vote_power_manager_top
// Power manager collecting client sleep votes and issuing sleep/wake results.
//
//   channel | signals                           | direction
//   request | in_valid in_ready in_data         | in
//   result  | out_valid out_ready out_data      | out
//   config  | psel penable pwrite paddr pwdata prdata pready | in/out
//
// A hold request passes through tag search, write and idle.
// A vote that ends in sleep passes through search,
// write, entry scan, mode scan, stamp, nearest-mode search, result, idle;
// a check request skips the write, an awake result skips stamp and search.
// Reset clears the table valid bits and the mode stamps at once.
// A held result stalls the sequencer until it is taken.
// ----------------------------------------------------------------------------
module sleep_vote_power_manager_top #(
  parameter int TABLE_ENTRIES = 16,
  parameter int NUM_MODES     = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  svpm_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output svpm_pkg::rsp_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic [1:0]  current_mode;
  logic [15:0] min_sleep_ms;
  logic [1:0]  reg_idx;
  svpm_pkg::cmd_t cmd;
  svpm_pkg::sts_t sts;

  assign pready = 1'b1;

  // register index from the word address
  assign reg_idx = {1'b0, paddr[2]};

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= '0;
      min_sleep_ms <= svpm_pkg::MIN_SLEEP_RESET;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == svpm_pkg::REG_CURRENT_MODE) current_mode <= pwdata[1:0];
      else if (reg_idx == svpm_pkg::REG_MIN_SLEEP) min_sleep_ms <= pwdata[15:0];
    end
  end

  // register reads
  always_comb begin
    if (reg_idx == svpm_pkg::REG_CURRENT_MODE) prdata = {30'd0, current_mode};
    else if (reg_idx == svpm_pkg::REG_MIN_SLEEP) prdata = {16'd0, min_sleep_ms};
    else prdata = '0;
  end

  svpm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready),
    .sts(sts), .in_ready(in_ready), .cmd(cmd)
  );

  svpm_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .NUM_MODES(NUM_MODES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(in_data),
    .current_mode(current_mode), .min_sleep_ms(min_sleep_ms),
    .sts(sts), .rsp_valid(out_valid), .rsp_ready(out_ready), .rsp(out_data)
  );

endmodule

FILE: hdl/svpm_ctrl.sv
// ----------------------------------------------------------------------------
// svpm_ctrl
// Sequencer: lookup, write, table scan, mode scan, stamp, nearest-mode search and result.
// ----------------------------------------------------------------------------
module svpm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  svpm_pkg::sts_t  sts,
  output logic            in_ready,
  output svpm_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOOK  = 8'b0000_0010,
    S_ALLOC = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_MODE  = 8'b0001_0000,
    S_STAMP = 8'b0010_0000,
    S_NEAR  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        if (sts.ent_done) state_next = sts.is_check ? S_SCAN : S_ALLOC;
      end
      S_ALLOC: begin
        if (sts.full) begin
          if (!sts.out_busy) begin
            cmd.emit_fin = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.alloc = 1'b1;
          state_next = sts.is_hold ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_ent = 1'b1;
        if (sts.ent_done) state_next = S_MODE;
      end
      S_MODE: begin
        if (sts.mode_done) state_next = sts.awake ? S_FIN : S_STAMP;
        else if (!(sts.wake_hit && sts.out_busy)) begin
          cmd.scan_mode = 1'b1;
          cmd.emit_wake = sts.wake_hit;
        end
      end
      S_STAMP: begin
        cmd.stamp = 1'b1;
        state_next = S_NEAR;
      end
      S_NEAR: begin
        cmd.near_step = 1'b1;
        if (sts.near_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.emit_fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_wake && cmd.emit_fin)) else $error("double emit");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_wake || cmd.emit_fin) |-> !sts.out_busy) else $error("emit into full output");

endmodule

FILE: hdl/svpm_dp.sv
// ----------------------------------------------------------------------------
// svpm_dp
// Vote table, mode stamps, scan accumulators and result register.
// ----------------------------------------------------------------------------
module svpm_dp #(
  parameter int TABLE_ENTRIES = 16,
  parameter int NUM_MODES     = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  svpm_pkg::cmd_t  cmd,
  input  svpm_pkg::req_t  req,
  input  logic [1:0]      current_mode,
  input  logic [15:0]     min_sleep_ms,
  output svpm_pkg::sts_t  sts,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output svpm_pkg::rsp_t  rsp
);

  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int MW = $clog2(NUM_MODES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int MCW = $clog2(NUM_MODES + 1);

  logic [TABLE_ENTRIES-1:0] ent_valid;
  logic [15:0] ent_tag      [TABLE_ENTRIES];
  logic [1:0]  ent_status   [TABLE_ENTRIES];
  logic [47:0] ent_deadline [TABLE_ENTRIES];
  logic [47:0] stamp        [NUM_MODES];

  svpm_pkg::req_t r;
  logic [CW-1:0]  ecnt;
  logic [MCW-1:0] mcnt;
  logic [EW-1:0]  eidx;
  logic [MW-1:0]  midx;
  logic [MW-1:0]  cur;
  logic [MW-1:0]  near;
  logic           found, free_found;
  logic [EW-1:0]  slot, free_slot;
  logic           awake;
  logic           grant_none;
  logic [30:0]    grant;
  logic [1:0]     nres;

  assign eidx = ecnt[EW-1:0];
  assign midx = mcnt[MW-1:0];

  // effective mode, clamped to the highest mode
  always_comb begin
    if ({30'd0, current_mode} >= 32'(NUM_MODES)) cur = MW'(NUM_MODES - 1);
    else cur = MW'(current_mode);
  end

  // per-entry remaining time
  logic signed [48:0] dl;
  assign dl = $signed({1'b0, ent_deadline[eidx]}) - $signed({1'b0, r.now_ms});

  // due flags of the later modes
  logic [NUM_MODES-1:0] due_mask;
  always_comb begin
    for (int m = 0; m < NUM_MODES; m++)
      due_mask[m] = (MW'(m) > cur) && (stamp[m] != '0) && (stamp[m] < r.now_ms);
  end

  // wake check on the mode under the counter
  logic mode_due;
  assign mode_due = due_mask[midx];

  // another due mode follows the one under the counter
  logic later_due;
  always_comb begin
    later_due = 1'b0;
    for (int m = 0; m < NUM_MODES; m++)
      if (MW'(m) > midx && due_mask[m]) later_due = 1'b1;
  end

  logic [47:0] grant48;
  assign grant48 = grant_none ? '1 : {17'd0, grant};

  assign sts.ent_done  = (ecnt == CW'(TABLE_ENTRIES - 1));
  assign sts.mode_done = (mcnt == MCW'(NUM_MODES));
  assign sts.near_done = (mcnt == MCW'(NUM_MODES - 1));
  assign sts.full      = !found && !free_found && (r.kind != svpm_pkg::KIND_CHECK);
  assign sts.is_hold   = (r.kind == svpm_pkg::KIND_HOLD);
  assign sts.is_check  = (r.kind == svpm_pkg::KIND_CHECK);
  assign sts.awake     = awake || (nres != 2'd0);
  assign sts.wake_hit  = mode_due;
  assign sts.out_busy  = rsp_valid && !rsp_ready;

  logic [EW-1:0] vslot;
  assign vslot = found ? slot : free_slot;

  // final result value
  logic signed [48:0] nd;
  logic [31:0] near_ms;
  assign nd = $signed({1'b0, stamp[near]}) - $signed({1'b0, r.now_ms});
  always_comb begin
    if (nd < 0) near_ms = 32'd0;
    else if (nd > 49'sd2147483647) near_ms = 32'h7fff_ffff;
    else near_ms = nd[31:0];
  end

  // table, stamps and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      for (int m = 0; m < NUM_MODES; m++) stamp[m] <= '0;
      ecnt <= '0;
      mcnt <= '0;
      rsp_valid <= 1'b0;
      found <= 1'b0;
      free_found <= 1'b0;
      awake <= 1'b0;
      grant_none <= 1'b1;
      grant <= '0;
      nres <= '0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (cmd.load) begin
        r <= req;
        ecnt <= '0;
        found <= 1'b0;
        free_found <= 1'b0;
        awake <= 1'b0;
        grant_none <= 1'b1;
        grant <= '0;
        nres <= '0;
      end
      if (cmd.lookup) begin
        if (ent_valid[eidx] && ent_tag[eidx] == r.client_tag && !found) begin
          found <= 1'b1;
          slot <= eidx;
        end
        if (!ent_valid[eidx] && !free_found) begin
          free_found <= 1'b1;
          free_slot <= eidx;
        end
        ecnt <= sts.ent_done ? '0 : ecnt + 1'b1;
      end
      if (cmd.alloc) begin
        ent_valid[vslot] <= 1'b1;
        ent_tag[vslot] <= r.client_tag;
        unique case (r.kind)
          svpm_pkg::KIND_HOLD: begin
            ent_deadline[vslot] <= r.now_ms + {17'd0, r.duration_ms};
            ent_status[vslot] <= svpm_pkg::ST_HOLD;
          end
          svpm_pkg::KIND_UNTIL: begin
            ent_deadline[vslot] <= r.now_ms + {17'd0, r.duration_ms};
            ent_status[vslot] <= svpm_pkg::ST_UNTIL;
          end
          default: begin
            if (!found) ent_deadline[vslot] <= '0;
            ent_status[vslot] <= svpm_pkg::ST_FREE;
          end
        endcase
        ecnt <= '0;
      end
      if (cmd.scan_ent) begin
        if (ent_valid[eidx]) begin
          if (ent_status[eidx] == svpm_pkg::ST_HOLD) begin
            if (dl > 0) awake <= 1'b1;
            else ent_status[eidx] <= svpm_pkg::ST_FREE;
          end else if (ent_status[eidx] == svpm_pkg::ST_UNTIL) begin
            if (dl < $signed({33'd0, min_sleep_ms})) begin
              ent_status[eidx] <= svpm_pkg::ST_HOLD;
              awake <= 1'b1;
            end else if (dl > 49'sd2147483647) begin
              if (grant_none) grant <= 31'h7fff_ffff;
              grant_none <= 1'b0;
            end else begin
              if (grant_none || dl[30:0] < grant) grant <= dl[30:0];
              grant_none <= 1'b0;
            end
          end
        end
        ecnt <= sts.ent_done ? '0 : ecnt + 1'b1;
        mcnt <= '0;
      end
      if (cmd.scan_mode) mcnt <= mcnt + 1'b1;
      if (cmd.emit_wake) begin
        if (nres != 2'(svpm_pkg::MAX_RESULTS)) begin
          rsp_valid <= 1'b1;
          rsp.action <= svpm_pkg::ACT_WAKE;
          rsp.sleep_ms <= '0;
          rsp.next_mode <= 2'(midx);
          // final wake result when no later mode is due or the cap is reached
          rsp.last <= !later_due || (nres == 2'(svpm_pkg::MAX_RESULTS - 1));
          nres <= nres + 1'b1;
        end
      end
      if (cmd.stamp) begin
        stamp[cur] <= r.now_ms + grant48;
        near <= cur;
        mcnt <= '0;
      end
      if (cmd.near_step) begin
        if (stamp[midx] != '0 && stamp[midx] < stamp[near]) near <= midx;
        mcnt <= mcnt + 1'b1;
      end
      // wake results already carried the last flag, nothing more to send
      if (cmd.emit_fin && nres == 2'd0) begin
        rsp_valid <= 1'b1;
        rsp.last <= 1'b1;
        if (sts.full) begin
          rsp.action <= svpm_pkg::ACT_FULL;
          rsp.sleep_ms <= '0;
          rsp.next_mode <= 2'(cur);
        end else if (awake) begin
          rsp.action <= svpm_pkg::ACT_AWAKE;
          rsp.sleep_ms <= '0;
          rsp.next_mode <= 2'(cur);
        end else begin
          rsp.action <= svpm_pkg::ACT_SLEEP;
          rsp.next_mode <= 2'(near);
          if (near == cur) rsp.sleep_ms <= grant_none ? -32'sd1 : {1'b0, grant};
          else rsp.sleep_ms <= near_ms;
        end
      end
    end
  end

  a_nres: assert property (@(posedge clk) disable iff (rst)
    nres <= 2'(svpm_pkg::MAX_RESULTS)) else $error("too many results");
  a_grant: assert property (@(posedge clk) disable iff (rst)
    grant_none |-> grant == '0) else $error("grant without vote");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> $stable(rsp)) else $error("result changed");

endmodule
